/* hdl/ioc_pkg.sv */
// Package for the I/O request coalescer.
// Holds the fixed field widths, the queue depth and the push control type.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ioc_pkg;

    localparam int OFFSET_BITS = 63;
    localparam int CAP_BITS    = 25;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256 * 1024);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic old_held;
        logic flush;
    } t_push;

endpackage

`default_nettype wire

/* hdl/ioc_merge_core.sv */
// Merge stage of the I/O request coalescer: held descriptor and merge decision.
// Depends on ioc_pkg; feeds ioc_out_queue through a t_push control struct.
`timescale 1ns / 1ps
`default_nettype none

module ioc_merge_core #(
    parameter int ADDRESS_BITS = 48,
    parameter int LENGTH_BITS  = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_accept,
    input  wire [ioc_pkg::OFFSET_BITS-1:0]   i_device_offset,
    input  wire [ADDRESS_BITS-1:0]           i_buffer_address,
    input  wire [LENGTH_BITS-1:0]            i_byte_length,
    input  wire                              i_batch_end,
    input  wire [ioc_pkg::CAP_BITS-1:0]      i_max_merge_bytes,
    output ioc_pkg::t_push                   o_push,
    output logic [ioc_pkg::OFFSET_BITS+ADDRESS_BITS+LENGTH_BITS:0] o_entry_old,
    output logic [ioc_pkg::OFFSET_BITS+ADDRESS_BITS+LENGTH_BITS:0] o_entry_new
);
    import ioc_pkg::*;

    localparam int OSUM_BITS = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;
    localparam int ASUM_BITS = ((ADDRESS_BITS > LENGTH_BITS) ? ADDRESS_BITS : LENGTH_BITS) + 1;
    localparam int LSUM_BITS = ((LENGTH_BITS + 1) > CAP_BITS) ? (LENGTH_BITS + 1) : CAP_BITS;

    logic                    r_holding;
    logic                    n_holding;
    logic [OFFSET_BITS-1:0]  r_held_offset;
    logic [OFFSET_BITS-1:0]  n_held_offset;
    logic [ADDRESS_BITS-1:0] r_held_address;
    logic [ADDRESS_BITS-1:0] n_held_address;
    logic [LENGTH_BITS-1:0]  r_held_length;
    logic [LENGTH_BITS-1:0]  n_held_length;

    logic [OSUM_BITS-1:0]    off_sum;
    logic [ASUM_BITS-1:0]    addr_sum;
    logic [LSUM_BITS-1:0]    len_sum;
    logic                    off_adj;
    logic                    addr_adj;
    logic                    size_ok;
    logic                    merge;

    // A sum that overflows the field width can never equal the zero-extended
    // input, so the adjacency compares also reject overflowing sums.
    assign off_sum  = OSUM_BITS'(r_held_offset) + OSUM_BITS'(r_held_length);
    assign addr_sum = ASUM_BITS'(r_held_address) + ASUM_BITS'(r_held_length);
    assign len_sum  = LSUM_BITS'(r_held_length) + LSUM_BITS'(i_byte_length);
    assign off_adj  = (off_sum == OSUM_BITS'(i_device_offset));
    assign addr_adj = (addr_sum == ASUM_BITS'(i_buffer_address));
    assign size_ok  = (len_sum <= LSUM_BITS'(i_max_merge_bytes));
    assign merge    = r_holding && (i_byte_length != '0) && off_adj && addr_adj && size_ok;

    always_comb begin
        n_holding      = r_holding;
        n_held_offset  = r_held_offset;
        n_held_address = r_held_address;
        n_held_length  = r_held_length;
        o_push         = '0;
        if (i_accept) begin
            if (merge) begin
                n_held_length = len_sum[LENGTH_BITS-1:0];
            end else begin
                n_held_offset   = i_device_offset;
                n_held_address  = i_buffer_address;
                n_held_length   = i_byte_length;
                o_push.old_held = r_holding;
            end
            o_push.flush = i_batch_end;
            n_holding    = !i_batch_end;
        end
    end

    assign o_entry_old = {r_held_offset, r_held_address, r_held_length, 1'b0};
    assign o_entry_new = {n_held_offset, n_held_address, n_held_length, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
        end else begin
            r_holding <= n_holding;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_offset  <= n_held_offset;
        r_held_address <= n_held_address;
        r_held_length  <= n_held_length;
    end

endmodule

`default_nettype wire

/* hdl/ioc_out_queue.sv */
// Output queue of the I/O request coalescer: up to two pushes, one pop a cycle.
// Depends on ioc_pkg for the depth and the t_push control struct.
`timescale 1ns / 1ps
`default_nettype none

module ioc_out_queue #(
    parameter int ENTRY_BITS = 144
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire ioc_pkg::t_push   i_push,
    input  wire [ENTRY_BITS-1:0]  i_entry_old,
    input  wire [ENTRY_BITS-1:0]  i_entry_new,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [ENTRY_BITS-1:0] o_entry
);
    import ioc_pkg::*;

    logic [ENTRY_BITS-1:0] r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr;
    logic [QPTR_BITS-1:0]  n_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr;
    logic [QPTR_BITS-1:0]  n_rd_ptr;
    logic [QPTR_BITS:0]    r_count;
    logic [QPTR_BITS:0]    n_count;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [ENTRY_BITS-1:0] first_data;
    logic [1:0]            push_cnt;
    logic                  pop;

    assign push_cnt    = {1'b0, i_push.old_held} + {1'b0, i_push.flush};
    assign first_data  = i_push.old_held ? i_entry_old : i_entry_new;
    assign wr_ptr_next = r_wr_ptr + QPTR_BITS'(1);
    assign pop         = o_valid && i_ready;

    assign o_valid = (r_count != '0);
    assign o_space = (r_count <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));
    assign o_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_BITS'(push_cnt);
        n_rd_ptr = pop ? (r_rd_ptr + QPTR_BITS'(1)) : r_rd_ptr;
        n_count  = r_count + (QPTR_BITS+1)'(push_cnt) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_slot[r_wr_ptr] <= first_data;
        end
        if (push_cnt == 2'd2) begin
            r_slot[wr_ptr_next] <= i_entry_new;
        end
    end

endmodule

`default_nettype wire

/* hdl/io_request_coalescer.sv */
// Top level of the I/O request coalescer: configuration register and wiring.
// Depends on ioc_pkg, ioc_merge_core and ioc_out_queue.
`timescale 1ns / 1ps
`default_nettype none

// The coalescer accepts one block I/O descriptor per clock cycle and merges
// each one into the held descriptor when it is contiguous on the device and
// in memory and the merged length stays within max_merge_bytes. A descriptor
// is emitted only when a non-mergeable request displaces it or when batch_end
// flushes it, so results lag their inputs by an unbounded number of items.
// A request that both displaces and flushes produces two results, which leave
// one after the other through a four-entry output queue; the input is ready
// whenever that queue has at least two free entries, so the sustained rate is
// one request per cycle while the output side keeps up. The configuration
// register is always ready and should only be written while the block is idle.
module io_request_coalescer #(
    parameter int ADDRESS_BITS = 48,
    parameter int LENGTH_BITS  = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [ioc_pkg::CAP_BITS-1:0]      i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [ioc_pkg::OFFSET_BITS-1:0]   i_device_offset,
    input  wire [ADDRESS_BITS-1:0]           i_buffer_address,
    input  wire [LENGTH_BITS-1:0]            i_byte_length,
    input  wire                              i_batch_end,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [ioc_pkg::OFFSET_BITS-1:0]  o_out_offset,
    output logic [ADDRESS_BITS-1:0]          o_out_address,
    output logic [LENGTH_BITS-1:0]           o_out_length,
    output logic                             o_out_final
);
    import ioc_pkg::*;

    localparam int ENTRY_BITS = OFFSET_BITS + ADDRESS_BITS + LENGTH_BITS + 1;

    logic [CAP_BITS-1:0]   r_max_merge_bytes;
    logic                  accept;
    t_push                 push;
    logic [ENTRY_BITS-1:0] entry_old;
    logic [ENTRY_BITS-1:0] entry_new;
    logic [ENTRY_BITS-1:0] entry_out;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_merge_bytes <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_max_merge_bytes <= i_cfg_data;
        end
    end

    ioc_merge_core #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_device_offset  (i_device_offset),
        .i_buffer_address (i_buffer_address),
        .i_byte_length    (i_byte_length),
        .i_batch_end      (i_batch_end),
        .i_max_merge_bytes(r_max_merge_bytes),
        .o_push           (push),
        .o_entry_old      (entry_old),
        .o_entry_new      (entry_new)
    );

    ioc_out_queue #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry_old(entry_old),
        .i_entry_new(entry_new),
        .o_space    (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_entry    (entry_out)
    );

    assign o_out_offset  = entry_out[ENTRY_BITS-1 -: OFFSET_BITS];
    assign o_out_address = entry_out[LENGTH_BITS+ADDRESS_BITS -: ADDRESS_BITS];
    assign o_out_length  = entry_out[LENGTH_BITS:1];
    assign o_out_final   = entry_out[0];

endmodule

`default_nettype wire

/* hdl/ioc_checker.sv */
// Port-level checks for the I/O request coalescer, bound to the top level.
// Depends on ioc_pkg for the fixed offset width.
`timescale 1ns / 1ps
`default_nettype none

module ioc_checker #(
    parameter int ADDRESS_BITS = 48,
    parameter int LENGTH_BITS  = 32
) (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_in_valid,
    input wire                            o_in_ready,
    input wire                            i_batch_end,
    input wire                            o_out_valid,
    input wire                            i_out_ready,
    input wire [ioc_pkg::OFFSET_BITS-1:0] o_out_offset,
    input wire [ADDRESS_BITS-1:0]         o_out_address,
    input wire [LENGTH_BITS-1:0]          o_out_length,
    input wire                            o_out_final
);
    import ioc_pkg::*;

    // A flushing transaction always leaves a result visible in the next cycle.
    a_flush_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_batch_end) |=> o_out_valid)
        else $error("flush transaction produced no result");

    // Straight after reset the queue is empty and the input side is open.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("queue not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_out_offset) && $stable(o_out_address)
            && $stable(o_out_length) && $stable(o_out_final)))
        else $error("result payload changed while stalled");

endmodule

bind io_request_coalescer ioc_checker #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
) u_ioc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_batch_end  (i_batch_end),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_offset (o_out_offset),
    .o_out_address(o_out_address),
    .o_out_length (o_out_length),
    .o_out_final  (o_out_final)
);

`default_nettype wire
